### rtl/lpfd_pkg.sv
// shared types and constants for the length-prefixed frame deframer
`default_nettype none

package lpfd_pkg;

    // header layout
    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned POS_W        = 3;

    // field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned KIND_W = 2;

    // header byte positions
    localparam logic [POS_W-1:0] POS_MAGIC0  = 3'd0;
    localparam logic [POS_W-1:0] POS_MAGIC1  = 3'd1;
    localparam logic [POS_W-1:0] POS_VERSION = 3'd2;
    localparam logic [POS_W-1:0] POS_TYPE    = 3'd3;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 3'd4;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DESYNC  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 2'd2;

    // configuration reset values
    localparam logic [BYTE_W-1:0] RST_MAGIC_FIRST  = 8'h43;
    localparam logic [BYTE_W-1:0] RST_MAGIC_SECOND = 8'h48;
    localparam logic [BYTE_W-1:0] RST_VERSION      = 8'h01;

    // configuration values seen by the core
    typedef struct packed {
        logic [BYTE_W-1:0] magic_first;
        logic [BYTE_W-1:0] magic_second;
        logic [BYTE_W-1:0] expected_version;
    } lpfd_cfg_t;

    // one result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] frame_type;
        logic [LEN_W-1:0]  payload_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              first_of_frame;
        logic              last_of_frame;
    } lpfd_result_t;

endpackage

`default_nettype wire

### rtl/lpfd_cfg.sv
// configuration register file for the deframer
`default_nettype none

module lpfd_cfg
    import lpfd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    output lpfd_cfg_t                 cfg
);

    lpfd_cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_first      <= RST_MAGIC_FIRST;
            cfg_reg.magic_second     <= RST_MAGIC_SECOND;
            cfg_reg.expected_version <= RST_VERSION;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAGIC_FIRST: begin
                    cfg_reg.magic_first <= cfg_data;
                end
                CFG_MAGIC_SECOND: begin
                    cfg_reg.magic_second <= cfg_data;
                end
                CFG_VERSION: begin
                    cfg_reg.expected_version <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/lpfd_core.sv
// header parser and payload tracker, one byte per accepted request
`default_nettype none

module lpfd_core
    import lpfd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  lpfd_cfg_t              cfg,
    output logic                   res_valid,
    output lpfd_result_t           res
);

    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic              match_reg,     match_next;
    logic [BYTE_W-1:0] type_reg,      type_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic [LEN_W-1:0]  remain_reg,    remain_next;
    logic              in_pay_reg,    in_pay_next;

    // next state and result for the incoming byte
    always_comb begin
        pos_next    = pos_reg;
        match_next  = match_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        in_pay_next = in_pay_reg;
        res_valid   = 1'b0;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = '0;
        res.first_of_frame = 1'b0;
        res.last_of_frame  = 1'b0;

        if (in_pay_reg) begin
            // payload byte passes through
            res_valid          = 1'b1;
            res.payload_byte   = rx_byte;
            res.first_of_frame = (remain_reg == len_reg);
            res.last_of_frame  = (remain_reg <= LEN_W'(1));
            if (remain_reg != '0) begin
                remain_next = remain_reg - LEN_W'(1);
            end
            if (remain_reg <= LEN_W'(1)) begin
                in_pay_next = 1'b0;
                pos_next    = POS_MAGIC0;
                match_next  = 1'b1;
            end
        end else begin
            case (pos_reg)
                POS_MAGIC0: begin
                    match_next = (rx_byte == cfg.magic_first);
                    pos_next   = POS_MAGIC1;
                end
                POS_MAGIC1: begin
                    match_next = match_reg && (rx_byte == cfg.magic_second);
                    pos_next   = POS_VERSION;
                end
                POS_VERSION: begin
                    match_next = match_reg && (rx_byte == cfg.expected_version);
                    pos_next   = POS_TYPE;
                end
                POS_TYPE: begin
                    type_next = rx_byte;
                    pos_next  = POS_LEN_HI;
                end
                POS_LEN_HI: begin
                    len_next = {rx_byte, {BYTE_W{1'b0}}};
                    pos_next = POS_LEN_LO;
                end
                default: begin
                    // last header byte: check and decide
                    len_next   = {len_reg[LEN_W-1:BYTE_W], rx_byte};
                    pos_next   = POS_MAGIC0;
                    match_next = 1'b1;
                    if (!match_reg) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_DESYNC;
                    end else if (len_next == '0) begin
                        res_valid         = 1'b1;
                        res.kind          = KIND_EMPTY;
                        res.last_of_frame = 1'b1;
                    end else begin
                        remain_next = len_next;
                        in_pay_next = 1'b1;
                    end
                end
            endcase
        end
        res.frame_type     = type_next;
        res.payload_length = len_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_MAGIC0;
            match_reg  <= 1'b1;
            type_reg   <= '0;
            len_reg    <= '0;
            remain_reg <= '0;
            in_pay_reg <= 1'b0;
        end else if (accept) begin
            pos_reg    <= pos_next;
            match_reg  <= match_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
            in_pay_reg <= in_pay_next;
        end
    end

endmodule

`default_nettype wire

### rtl/lpfd_out.sv
// result register with a skid entry so the input keeps flowing while one result waits
`default_nettype none

module lpfd_out
    import lpfd_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  lpfd_result_t push_data,
    output logic        can_take,
    output logic        out_valid,
    output lpfd_result_t out_data,
    input  wire logic   out_ready
);

    logic         main_valid_reg;
    lpfd_result_t main_reg;
    logic         skid_valid_reg;
    lpfd_result_t skid_reg;

    // control bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
            end else if (push) begin
                main_reg <= push_data;
            end
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

    assign can_take  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

`default_nettype wire

### rtl/length_prefixed_frame_deframer_unit.sv
// top level of the length-prefixed frame deframer
//
// Takes one received byte per request on the s_ channel and parses a six-byte
// header: two magic bytes, a version byte, a type byte and a big-endian 16-bit
// length. A bad magic or version gives one desync result after the sixth
// header byte; a good header with zero length gives one empty-frame result;
// otherwise each following payload byte comes out on the m_ channel with the
// frame type, length and first/last marks (last on m_tlast).
// Expected magic and version bytes are written on the cfg_ channel
// (index 0 first magic, 1 second magic, 2 version); write only while idle.
// Throughput is one byte per cycle while s_tready is high; each result is
// registered in the output buffer before it appears on m_.
// A two-entry output buffer lets a new byte be taken while a result waits;
// when m_tready stays low the buffer fills and s_tready drops until it drains.
// Synchronous reset clears the parser to the start of a header, empties the
// output buffer and restores the register defaults 'C', 'H' and 1.
`default_nettype none

module length_prefixed_frame_deframer_unit
    import lpfd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // byte input
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
    // result output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,   // [7:0] frame_type, [23:8] payload_length,
                                                 // [31:24] payload_byte
    output logic [2:0]                m_tuser,   // [1:0] kind, [2] first_of_frame
    output logic                      m_tlast,   // last_of_frame
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data
);

    lpfd_cfg_t    cfg;
    logic         accept;
    logic         res_valid;
    lpfd_result_t res;
    lpfd_result_t out_res;
    logic         can_take;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_take;
    assign accept    = s_tvalid && can_take;

    lpfd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lpfd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    lpfd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && res_valid),
        .push_data (res),
        .can_take  (can_take),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    // pack the result onto the stream
    assign m_tdata = {out_res.payload_byte, out_res.payload_length, out_res.frame_type};
    assign m_tuser = {out_res.first_of_frame, out_res.kind};
    assign m_tlast = out_res.last_of_frame;

endmodule

`default_nettype wire
